// ===== rtl/rmoi_pkg.sv =====
// ----------------------------------------------------------------------------
// rmoi_pkg
// shared types and constants of the region map with overlay insert
// ----------------------------------------------------------------------------
package rmoi_pkg;

	// default table depth
	localparam int MAX_REGIONS_DEF = 64;

	// command codes of one item
	typedef enum logic [1:0] {
		KIND_CLEAR  = 2'd0,
		KIND_APPEND = 2'd1,
		KIND_INSERT = 2'd2,
		KIND_READ   = 2'd3
	} kind_t;

	// result status codes
	typedef enum logic [1:0] {
		STAT_OK       = 2'd0,
		STAT_OVERFLOW = 2'd1,
		STAT_RANGE    = 2'd2
	} status_t;

	// sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_EVAL,
		ST_PUSH,
		ST_TAIL
	} state_t;

	// one stored region
	typedef struct packed {
		logic [63:0] start_addr;
		logic [63:0] end_addr;
		logic [3:0]  region_type;
	} region_t;

	// one input item
	typedef struct packed {
		kind_t       kind;
		logic [63:0] start_addr;
		logic [63:0] end_addr;
		logic [3:0]  region_type;
		logic [5:0]  read_index;
	} cmd_t;

	// one result item
	typedef struct packed {
		logic [63:0] entry_start;
		logic [63:0] entry_end;
		logic [3:0]  entry_type;
		logic [6:0]  entry_count;
		status_t     status;
	} result_t;

endpackage

// ===== rtl/region_map_overlay_insert.sv =====
// ----------------------------------------------------------------------------
// region_map_overlay_insert
// ordered table of address regions with clear, append, read and overlay insert
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low; its single result
// appears on result for exactly one cycle with done high and cannot be held
// off. Clear, append and a read past the count finish in the idle state; an
// in-range read also passes through the read state. An overlay insert
// rebuilds a table of n entries into w entries through one synchronous
// memory with one read and one write port: every rebuilt entry costs one
// write, so a source entry takes as many steps as the entries it yields,
// and at least one. The memory holds two banks, each with room for
// MAX_REGIONS entries; an insert writes the spare bank and only swaps banks
// when it finishes without overflow, so an overflowing insert leaves the
// table untouched. The table needs no clearing pass after reset: only
// entries below the count are ever used.
// ----------------------------------------------------------------------------
module region_map_overlay_insert #(
	parameter int MAX_REGIONS = rmoi_pkg::MAX_REGIONS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  rmoi_pkg::cmd_t    item,
	output logic              done,
	output rmoi_pkg::result_t result
);
	import rmoi_pkg::*;

	localparam int IW   = $clog2(MAX_REGIONS);          // entry index width
	localparam int CW   = $clog2(MAX_REGIONS + 1);      // count width
	localparam int AW   = IW + 1;                       // bank bit plus index
	localparam int CMPW = (CW > 6) ? CW : 6;            // read index compare width
	localparam int DEPTH = 2 * (2 ** IW);

	// two-bank region memory
	region_t mem [0:DEPTH-1];
	region_t rd_q;

	// control state
	state_t          state_q, state_d;
	logic            bank_q;
	logic [CW-1:0]   count_q;      // entries in active bank
	logic [CW-1:0]   wcnt_q;       // entries written to spare bank
	logic [IW-1:0]   k_q;          // source entry under evaluation
	logic            placed_q;     // new region already written
	logic            copy_q;       // past the first right fragment
	logic [2:0]      rest_q;       // writes still owed by the held entry
	logic            done_q;

	// payload registers
	cmd_t            cmd_q;
	region_t         cur_q;
	logic            ov_q;
	result_t         result_q;

	// datapath decisions
	logic            accept;
	logic            rd_in_range;
	logic            more_src;
	logic            ev_before, ev_after, ev_ov;
	logic [2:0]      ev_mask;
	logic [2:0]      mask, first, rest_next;
	logic            ov_sel;
	region_t         src;
	logic            push_req;
	region_t         push_data;
	logic            overflow;

	// memory ports
	logic            mem_we;
	logic [AW-1:0]   mem_wa;
	region_t         mem_wd;
	logic            mem_re;
	logic [AW-1:0]   mem_ra;

	// result load
	logic            res_load;
	result_t         res_d;

	assign accept      = start && !busy;
	assign rd_in_range = CMPW'(item.read_index) < CMPW'(count_q);
	assign more_src    = (CW'(k_q) + CW'(1)) < count_q;

	// classify the fetched entry against the new region
	always_comb begin
		ev_before = rd_q.end_addr <= cmd_q.start_addr;
		ev_after  = !ev_before && (rd_q.start_addr >= cmd_q.end_addr);
		ev_ov     = !copy_q && !ev_before && !ev_after;
		if (copy_q || ev_before) begin
			ev_mask = 3'b100;
		end else if (ev_after) begin
			ev_mask = {1'b1, !placed_q, 1'b0};
		end else begin
			ev_mask = {rd_q.end_addr > cmd_q.end_addr, !placed_q,
				rd_q.start_addr < cmd_q.start_addr};
		end
	end

	// pick the next write of the rebuild: left fragment, new region, then
	// kept entry or right fragment
	always_comb begin
		mask   = 3'b000;
		src    = rd_q;
		ov_sel = 1'b0;
		unique case (state_q)
			ST_EVAL: begin
				mask   = ev_mask;
				src    = rd_q;
				ov_sel = ev_ov;
			end
			ST_PUSH: begin
				mask   = rest_q;
				src    = cur_q;
				ov_sel = ov_q;
			end
			ST_TAIL: begin
				mask = {1'b0, !placed_q, 1'b0};
			end
			ST_IDLE, ST_READ: begin
				mask = 3'b000;
			end
			default: begin
				mask = 3'b000;
			end
		endcase
		first     = mask & (~mask + 3'b001);
		rest_next = mask & ~first;
		push_req  = 1'b1;
		push_data = src;
		case (first)
			3'b001: begin
				push_data = region_t'{start_addr: src.start_addr, end_addr: cmd_q.start_addr,
					region_type: src.region_type};
			end
			3'b010: begin
				push_data = region_t'{start_addr: cmd_q.start_addr, end_addr: cmd_q.end_addr,
					region_type: cmd_q.region_type};
			end
			3'b100: begin
				push_data = ov_sel ? region_t'{start_addr: cmd_q.end_addr,
					end_addr: src.end_addr, region_type: src.region_type} : src;
			end
			default: begin
				push_req = 1'b0;
			end
		endcase
		overflow = push_req && (wcnt_q == CW'(MAX_REGIONS));
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					unique case (item.kind)
						KIND_INSERT: state_d = (count_q == '0) ? ST_TAIL : ST_EVAL;
						KIND_READ:   state_d = rd_in_range ? ST_READ : ST_IDLE;
						KIND_CLEAR, KIND_APPEND: state_d = ST_IDLE;
						default:     state_d = ST_IDLE;
					endcase
				end
			end
			ST_READ: begin
				state_d = ST_IDLE;
			end
			ST_EVAL, ST_PUSH: begin
				if (overflow) begin
					state_d = ST_IDLE;
				end else if (rest_next != 3'b000) begin
					state_d = ST_PUSH;
				end else begin
					state_d = more_src ? ST_EVAL : ST_TAIL;
				end
			end
			ST_TAIL: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// memory ports and result
	always_comb begin
		mem_we   = 1'b0;
		mem_wa   = {!bank_q, wcnt_q[IW-1:0]};
		mem_wd   = push_data;
		mem_re   = 1'b0;
		mem_ra   = {bank_q, k_q + IW'(1)};
		res_load = 1'b0;
		res_d    = '{entry_start: '0, entry_end: '0, entry_type: '0,
			entry_count: 7'(count_q), status: STAT_OK};
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					unique case (item.kind)
						KIND_CLEAR: begin
							res_load          = 1'b1;
							res_d.entry_count = '0;
						end
						KIND_APPEND: begin
							res_load = 1'b1;
							if (count_q == CW'(MAX_REGIONS)) begin
								res_d.status = STAT_OVERFLOW;
							end else begin
								mem_we            = 1'b1;
								mem_wa            = {bank_q, count_q[IW-1:0]};
								mem_wd            = '{start_addr: item.start_addr,
									end_addr: item.end_addr, region_type: item.region_type};
								res_d.entry_count = 7'(count_q + CW'(1));
							end
						end
						KIND_INSERT: begin
							mem_re = 1'b1;
							mem_ra = {bank_q, {IW{1'b0}}};
						end
						KIND_READ: begin
							if (rd_in_range) begin
								mem_re = 1'b1;
								mem_ra = {bank_q, IW'(item.read_index)};
							end else begin
								res_load     = 1'b1;
								res_d.status = STAT_RANGE;
							end
						end
						default: begin
							res_load = 1'b0;
						end
					endcase
				end
			end
			ST_READ: begin
				res_load          = 1'b1;
				res_d.entry_start = rd_q.start_addr;
				res_d.entry_end   = rd_q.end_addr;
				res_d.entry_type  = rd_q.region_type;
			end
			ST_EVAL, ST_PUSH: begin
				// prefetch the next source entry while the held one is written
				mem_re = (state_q == ST_EVAL);
				mem_we = push_req && !overflow;
				if (overflow) begin
					res_load     = 1'b1;
					res_d.status = STAT_OVERFLOW;
				end
			end
			ST_TAIL: begin
				mem_we   = push_req && !overflow;
				res_load = 1'b1;
				if (overflow) begin
					res_d.status = STAT_OVERFLOW;
				end else begin
					res_d.entry_count = 7'(wcnt_q + CW'(push_req));
				end
			end
			default: begin
				res_load = 1'b0;
			end
		endcase
	end

	// region memory, one write and one registered read port
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		if (mem_re) begin
			rd_q <= mem[mem_ra];
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			bank_q   <= 1'b0;
			count_q  <= '0;
			wcnt_q   <= '0;
			k_q      <= '0;
			placed_q <= 1'b0;
			copy_q   <= 1'b0;
			rest_q   <= 3'b000;
			done_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= res_load;
			unique case (state_q)
				ST_IDLE: begin
					wcnt_q   <= '0;
					k_q      <= '0;
					placed_q <= 1'b0;
					copy_q   <= 1'b0;
					if (accept && item.kind == KIND_CLEAR) begin
						count_q <= '0;
					end else if (accept && item.kind == KIND_APPEND &&
						count_q != CW'(MAX_REGIONS)) begin
						count_q <= count_q + CW'(1);
					end
				end
				ST_EVAL, ST_PUSH: begin
					rest_q <= rest_next;
					if (mem_we) begin
						wcnt_q <= wcnt_q + CW'(1);
					end
					if (first == 3'b010) begin
						placed_q <= 1'b1;
					end
					if (first == 3'b100 && ov_sel) begin
						copy_q <= 1'b1;
					end
					if (rest_next == 3'b000) begin
						k_q <= k_q + IW'(1);
					end
				end
				ST_TAIL: begin
					if (!overflow) begin
						bank_q  <= !bank_q;
						count_q <= wcnt_q + CW'(push_req);
					end
				end
				ST_READ: begin
					rest_q <= 3'b000;
				end
				default: begin
					rest_q <= 3'b000;
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= item;
		end
		if (state_q == ST_EVAL) begin
			cur_q <= rd_q;
			ov_q  <= ev_ov;
		end
		if (res_load) begin
			result_q <= res_d;
		end
	end

	assign busy   = (state_q != ST_IDLE);
	assign done   = done_q;
	assign result = result_q;

`ifndef SYNTHESIS
	// table never holds more than its depth
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_REGIONS))
		else $error("region count beyond table depth");

	// a held entry in the push state always owes a write
	a_push_owes: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_PUSH |-> rest_q != 3'b000)
		else $error("push state with nothing to write");

	// a result is only shown once the sequencer is back at rest
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while busy");

	// a rebuild never writes into the live bank
	a_spare_bank: assert property (@(posedge clk) disable iff (!arst_n)
		(mem_we && (mem_wa[IW] == bank_q)) |-> state_q == ST_IDLE)
		else $error("rebuild write into active bank");

	// an insert that finished without overflow swaps banks
	a_bank_swap: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_TAIL && !overflow) |=> bank_q != $past(bank_q))
		else $error("insert committed without bank swap");
`endif

endmodule
